[hw/rtl/cmsf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN message serial framer package
// Shared record type, frame layout positions and checksum constants.
// ----------------------------------------------------------------------------
package cmsf_pkg;

    localparam logic [7:0] FRAME_START = 8'h00;
    localparam logic [7:0] FRAME_SYNC  = 8'h55;
    localparam logic [7:0] RECORD_LEN  = 8'd24;
    localparam logic [8:0] SUM_MOD     = 9'd255;

    typedef logic [4:0] pos_t;

    // Byte positions inside the 30-byte frame
    localparam pos_t POS_START     = 5'd0;
    localparam pos_t POS_SYNC      = 5'd1;
    localparam pos_t POS_FNUM      = 5'd2;
    localparam pos_t POS_LEN       = 5'd3;
    localparam pos_t POS_REC_FIRST = 5'd4;
    localparam pos_t POS_REC_LAST  = 5'd27;
    localparam pos_t POS_SUM0      = 5'd28;
    localparam pos_t POS_SUM1      = 5'd29;

    // One queued frame request
    typedef struct packed {
        logic [15:0] count;
        logic [7:0]  frame_num;
        logic [7:0]  bus_number;
        logic [31:0] time_us;
        logic [28:0] can_id;
        logic        extended;
        logic [3:0]  data_length;
        logic [15:0] timeout_ms;
        logic [63:0] payload;
    } frame_req_t;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

[hw/rtl/can_message_serial_framer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN message serial framer
// Turns received CAN messages into checksummed serial frames.
// ----------------------------------------------------------------------------
// Each accepted message advances a 16-bit message count. When link_up is
// set, the message becomes a 30-byte frame: 0x00, 0x55, frame number, 24,
// a 24-byte little-endian record (count, bus, pad, timestamp, id, ext, len,
// timeout, data) and the two Fletcher-16 sums, low sum first; frame_end
// marks the last byte. A message taken with link_up clear produces no bytes.
// The front end takes each message and queues a frame request in a
// two-entry queue; the serializer drains one byte per cycle while
// out_stall is low. The front end keeps accepting while the queue has
// room, so a message can be taken while the previous frame is still
// going out. in_stall rises only when two frames are waiting.
// ----------------------------------------------------------------------------
module can_message_serial_framer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  bus_number,
    input  logic [31:0] time_us,
    input  logic [28:0] can_id,
    input  logic        extended,
    input  logic [3:0]  data_length,
    input  logic [15:0] timeout_ms,
    input  logic [63:0] payload,
    input  logic        link_up,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        frame_end
);

    cmsf_pkg::frame_req_t push_req;
    cmsf_pkg::frame_req_t head_req;
    cmsf_pkg::q_status_t  q_status;
    logic                 push;
    logic                 pop;

    // Front end: count messages, number frames, queue requests
    cmsf_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .bus_number  (bus_number),
        .time_us     (time_us),
        .can_id      (can_id),
        .extended    (extended),
        .data_length (data_length),
        .timeout_ms  (timeout_ms),
        .payload     (payload),
        .link_up     (link_up),
        .q_status    (q_status),
        .push        (push),
        .push_req    (push_req)
    );

    // Request queue decouples intake from serialization
    cmsf_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_req (push_req),
        .pop      (pop),
        .head_req (head_req),
        .q_status (q_status)
    );

    // Serializer: emit frame bytes and build the checksum
    cmsf_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_req  (head_req),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .frame_end (frame_end)
    );

    // After a queued request the output is valid on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        push |=> out_valid)
        else $error("queued request not visible at output");

    // A frame that starts from an idle output begins with the start byte
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (out_byte == cmsf_pkg::FRAME_START) && !frame_end)
        else $error("frame did not begin at start byte");

    // Last byte pops the queue; a pop only happens on an accepted last byte
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> out_valid && !out_stall && frame_end)
        else $error("queue popped outside frame end");

endmodule

[hw/rtl/cmsf_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN message serial framer front end
// Accepts messages, advances the message count and frame number, and
// pushes a frame request when the link is up.
// ----------------------------------------------------------------------------
module cmsf_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             bus_number,
    input  logic [31:0]            time_us,
    input  logic [28:0]            can_id,
    input  logic                   extended,
    input  logic [3:0]             data_length,
    input  logic [15:0]            timeout_ms,
    input  logic [63:0]            payload,
    input  logic                   link_up,
    input  cmsf_pkg::q_status_t    q_status,
    output logic                   push,
    output cmsf_pkg::frame_req_t   push_req
);

    logic [15:0] count_reg;
    logic [15:0] count_next;
    logic [7:0]  fnum_reg;
    logic [7:0]  fnum_next;
    logic        accept;

    assign in_stall   = q_status.full;
    assign accept     = in_valid && !in_stall;
    assign push       = accept && link_up;
    assign count_next = count_reg + 16'd1;
    assign fnum_next  = fnum_reg + 8'd1;

    always_comb
    begin
        push_req.count       = count_next;
        push_req.frame_num   = fnum_reg;
        push_req.bus_number  = bus_number;
        push_req.time_us     = time_us;
        push_req.can_id      = can_id;
        push_req.extended    = extended;
        push_req.data_length = data_length;
        push_req.timeout_ms  = timeout_ms;
        push_req.payload     = payload;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            fnum_reg  <= '0;
        end
        else
        begin
            // count advances on every message, frame number only on sent ones
            if (accept)
                count_reg <= count_next;
            if (push)
                fnum_reg <= fnum_next;
        end
    end

endmodule

[hw/rtl/cmsf_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN message serial framer request queue
// Two-entry queue between the front end and the serializer.
// ----------------------------------------------------------------------------
module cmsf_queue
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  cmsf_pkg::frame_req_t   push_req,
    input  logic                   pop,
    output cmsf_pkg::frame_req_t   head_req,
    output cmsf_pkg::q_status_t    q_status
);

    cmsf_pkg::frame_req_t mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    assign head_req       = mem[rd_ptr_reg];
    assign q_status.full  = (cnt_reg == 2'd2);
    assign q_status.empty = (cnt_reg == 2'd0);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_req;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_next;
        end
    end

endmodule

[hw/rtl/cmsf_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN message serial framer serializer
// Sends the queued request as a 30-byte frame, one byte per accepted
// output, and folds record bytes into the Fletcher-16 sums on the way.
// ----------------------------------------------------------------------------
module cmsf_back
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmsf_pkg::frame_req_t   head_req,
    input  cmsf_pkg::q_status_t    q_status,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [7:0]             out_byte,
    output logic                   frame_end
);

    cmsf_pkg::pos_t pos_reg;
    logic [7:0]     s0_reg;
    logic [7:0]     s1_reg;
    logic [7:0]     s0_next;
    logic [7:0]     s1_next;
    logic [8:0]     s0_sum;
    logic [8:0]     s1_sum;
    logic [191:0]   rec_vec;
    logic [4:0]     rec_idx;
    logic [7:0]     rec_byte;
    logic           out_take;
    logic           in_record;

    // record, byte 0 in the low bits
    assign rec_vec = {head_req.payload,
                      head_req.timeout_ms,
                      4'b0000, head_req.data_length,
                      7'b0000000, head_req.extended,
                      3'b000, head_req.can_id,
                      head_req.time_us,
                      8'h00,
                      head_req.bus_number,
                      head_req.count};

    assign rec_idx   = pos_reg - cmsf_pkg::POS_REC_FIRST;
    assign rec_byte  = rec_vec[{rec_idx, 3'b000} +: 8];
    assign in_record = (pos_reg >= cmsf_pkg::POS_REC_FIRST)
                    && (pos_reg <= cmsf_pkg::POS_REC_LAST);

    assign out_valid = !q_status.empty;
    assign out_take  = out_valid && !out_stall;
    assign frame_end = (pos_reg == cmsf_pkg::POS_SUM1);
    assign pop       = out_take && frame_end;

    always_comb
    begin
        unique case (pos_reg)
            cmsf_pkg::POS_START: out_byte = cmsf_pkg::FRAME_START;
            cmsf_pkg::POS_SYNC:  out_byte = cmsf_pkg::FRAME_SYNC;
            cmsf_pkg::POS_FNUM:  out_byte = head_req.frame_num;
            cmsf_pkg::POS_LEN:   out_byte = cmsf_pkg::RECORD_LEN;
            cmsf_pkg::POS_SUM0:  out_byte = s0_reg;
            cmsf_pkg::POS_SUM1:  out_byte = s1_reg;
            default:             out_byte = rec_byte;
        endcase
    end

    // mod-255 update: each sum stays below 510, so one subtract suffices
    always_comb
    begin
        s0_sum  = {1'b0, s0_reg} + {1'b0, rec_byte};
        s0_next = (s0_sum >= cmsf_pkg::SUM_MOD) ? 8'(s0_sum - cmsf_pkg::SUM_MOD)
                                                : s0_sum[7:0];
        s1_sum  = {1'b0, s1_reg} + {1'b0, s0_next};
        s1_next = (s1_sum >= cmsf_pkg::SUM_MOD) ? 8'(s1_sum - cmsf_pkg::SUM_MOD)
                                                : s1_sum[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= cmsf_pkg::POS_START;
            s0_reg  <= '0;
            s1_reg  <= '0;
        end
        else if (out_take)
        begin
            if (frame_end)
            begin
                pos_reg <= cmsf_pkg::POS_START;
                s0_reg  <= '0;
                s1_reg  <= '0;
            end
            else
            begin
                pos_reg <= pos_reg + 5'd1;
                if (in_record)
                begin
                    s0_reg <= s0_next;
                    s1_reg <= s1_next;
                end
            end
        end
    end

endmodule

[tb/tb_can_message_serial_framer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN message serial framer testbench
// Sends CAN message requests, predicts the 30-byte checksummed frame for
// each one, and checks every byte that leaves the block, in order.
// ----------------------------------------------------------------------------
module tb_can_message_serial_framer;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int DRAIN_CYCLES = 64;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 380;
    localparam int PHASE_ITEMS  = 50;

    // One CAN message request as it is offered to the block
    typedef struct {
        logic [7:0]  bus_number;
        logic [31:0] time_us;
        logic [28:0] can_id;
        logic        extended;
        logic [3:0]  data_length;
        logic [15:0] timeout_ms;
        logic [63:0] payload;
        logic        link_up;
    } can_msg_t;

    // One predicted frame byte
    typedef struct {
        logic [7:0] value;
        logic       last;
    } frame_byte_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  bus_number;
    logic [31:0] time_us;
    logic [28:0] can_id;
    logic        extended;
    logic [3:0]  data_length;
    logic [15:0] timeout_ms;
    logic [63:0] payload;
    logic        link_up;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  out_byte;
    logic        frame_end;

    // Predictor state: mirrors the block's message count and frame number
    logic [15:0] msg_count;
    logic [7:0]  frame_num;

    // Frame bytes still owed by the block, oldest first
    frame_byte_t expected_bytes[$];

    int          mismatches  = 0;
    int unsigned cycle_count = 0;

    // Pacing knobs shared by the sender, the receiver and the tests
    int tx_max_gap;
    int rx_max_wait;
    int rx_hold_len;

    can_message_serial_framer uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .bus_number  (bus_number),
        .time_us     (time_us),
        .can_id      (can_id),
        .extended    (extended),
        .data_length (data_length),
        .timeout_ms  (timeout_ms),
        .payload     (payload),
        .link_up     (link_up),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .frame_end   (frame_end)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    function automatic void expect_byte(input logic [7:0] value, input logic last);
        frame_byte_t b;
        b.value = value;
        b.last  = last;
        expected_bytes.push_back(b);
    endfunction

    // Advance the count for every request; queue the whole frame only when
    // the link is up. The record carries the count after the increment and
    // the frame carries the frame number before it.
    function automatic void build_expected_frame(input can_msg_t m);
        logic [7:0]  rec[24];
        logic [31:0] id_word;
        int          s0;
        int          s1;
        int          i;
        msg_count = msg_count + 16'd1;
        if (!m.link_up)
        begin
            return;
        end
        id_word = {3'b000, m.can_id};
        rec[0]  = msg_count[7:0];
        rec[1]  = msg_count[15:8];
        rec[2]  = m.bus_number;
        rec[3]  = 8'h00;
        for (i = 0; i < 4; i++)
        begin
            rec[4 + i] = m.time_us[8 * i +: 8];
            rec[8 + i] = id_word[8 * i +: 8];
        end
        rec[12] = {7'b0, m.extended};
        rec[13] = {4'b0, m.data_length};
        rec[14] = m.timeout_ms[7:0];
        rec[15] = m.timeout_ms[15:8];
        for (i = 0; i < 8; i++)
        begin
            rec[16 + i] = m.payload[8 * i +: 8];
        end
        // Fletcher-16, both sums reduced after every record byte
        s0 = 0;
        s1 = 0;
        for (i = 0; i < 24; i++)
        begin
            s0 = (s0 + int'(rec[i])) % int'(cmsf_pkg::SUM_MOD);
            s1 = (s1 + s0) % int'(cmsf_pkg::SUM_MOD);
        end
        expect_byte(cmsf_pkg::FRAME_START, 1'b0);
        expect_byte(cmsf_pkg::FRAME_SYNC, 1'b0);
        expect_byte(frame_num, 1'b0);
        expect_byte(cmsf_pkg::RECORD_LEN, 1'b0);
        for (i = 0; i < 24; i++)
        begin
            expect_byte(rec[i], 1'b0);
        end
        expect_byte(s0[7:0], 1'b0);
        expect_byte(s1[7:0], 1'b1);
        frame_num = frame_num + 8'd1;
    endfunction

    // ------------------------------------------------------------------------
    // Message builders
    // ------------------------------------------------------------------------

    function automatic can_msg_t make_message(
        input logic [7:0]  bus,
        input logic [31:0] stamp,
        input logic [28:0] id,
        input logic        ext,
        input logic [3:0]  len,
        input logic [15:0] tmo,
        input logic [63:0] data,
        input logic        link);
        can_msg_t m;
        m.bus_number  = bus;
        m.time_us     = stamp;
        m.can_id      = id;
        m.extended    = ext;
        m.data_length = len;
        m.timeout_ms  = tmo;
        m.payload     = data;
        m.link_up     = link;
        return m;
    endfunction

    // Mostly well-formed traffic: standard ids stay in 11 bits and lengths
    // in 0..8, with a share of odd ids and over-long lengths mixed in.
    function automatic can_msg_t random_message(input int link_pct);
        can_msg_t m;
        m.bus_number = 8'($urandom_range(0, 255));
        m.time_us    = $urandom;
        m.extended   = 1'($urandom_range(0, 1));
        if (m.extended || $urandom_range(0, 9) == 0)
        begin
            m.can_id = 29'($urandom_range(0, 32'h1FFF_FFFF));
        end
        else
        begin
            m.can_id = 29'($urandom_range(0, 32'h7FF));
        end
        if ($urandom_range(0, 4) == 0)
        begin
            m.data_length = 4'($urandom_range(0, 15));
        end
        else
        begin
            m.data_length = 4'($urandom_range(0, 8));
        end
        m.timeout_ms = 16'($urandom_range(0, 65535));
        m.payload    = {$urandom, $urandom};
        m.link_up    = ($urandom_range(1, 100) <= link_pct);
        return m;
    endfunction

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Offer one request after a random gap and hold it until accepted.
    // Leave in_valid high on return so a back-to-back request never lowers
    // and raises it in the same step.
    task automatic send_message(input can_msg_t m);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        bus_number  <= m.bus_number;
        time_us     <= m.time_us;
        can_id      <= m.can_id;
        extended    <= m.extended;
        data_length <= m.data_length;
        timeout_ms  <= m.timeout_ms;
        payload     <= m.payload;
        link_up     <= m.link_up;
        in_valid    <= 1'b1;
        do @(posedge clk); while (in_stall);
        build_expected_frame(m);
    endtask

    // Drop the request first so the last one is not taken again
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver pacing: draw a stall before every byte, or take a long hold
    // when a test asks for one, counted here in clock cycles.
    // ------------------------------------------------------------------------

    initial
    begin : rx_pacing
        int wait_cycles;
        out_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (rx_hold_len > 0)
            begin
                wait_cycles = rx_hold_len;
                rx_hold_len = 0;
            end
            else
            begin
                wait_cycles = $urandom_range(0, rx_max_wait);
            end
            if (wait_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("tb: mismatch on %s at cycle %0d: expected %0h, got %0h",
                 what, cycle_count, want, got);
        mismatches++;
    endtask

    // Compare every accepted byte with the oldest prediction
    always @(posedge clk)
    begin
        frame_byte_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_bytes.size() == 0)
            begin
                report_mismatch("unexpected byte", 0, int'(out_byte));
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (out_byte !== want.value)
                begin
                    report_mismatch("out_byte", int'(want.value), int'(out_byte));
                end
                if (frame_end !== want.last)
                begin
                    report_mismatch("frame_end", int'(want.last), int'(frame_end));
                end
            end
        end
    end

    // Watchdog: drop the run if it hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Field extremes, every odd length code and some even ones, link down
    // between frames and checksum bytes that hit the modulus.
    task automatic test_directed();
        int len;
        tx_max_gap  = 0;
        rx_max_wait = 0;
        send_message(make_message(8'h00, 32'h0, 29'h0, 1'b0, 4'd0, 16'h0, 64'h0, 1'b1));
        send_message(make_message(8'hFF, 32'hFFFF_FFFF, 29'h1FFF_FFFF, 1'b1, 4'd15,
                                  16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1));
        // Link down: count advances, frame number holds
        send_message(make_message(8'hFF, 32'hFFFF_FFFF, 29'h1FFF_FFFF, 1'b1, 4'd15,
                                  16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0));
        send_message(make_message(8'h00, 32'h0, 29'h0, 1'b0, 4'd0, 16'h0, 64'h0, 1'b0));
        send_message(make_message(8'h01, 32'h0000_0001, 29'h7FF, 1'b0, 4'd8, 16'h0001,
                                  64'h0807_0605_0403_0201, 1'b1));
        send_message(make_message(8'h80, 32'h8000_0000, 29'h1000_0000, 1'b1, 4'd8,
                                  16'h8000, 64'h8000_0000_0000_0000, 1'b1));
        send_message(make_message(8'hAA, 32'hAAAA_AAAA, 29'h0AAA_AAAA, 1'b0, 4'd10,
                                  16'hAAAA, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1));
        send_message(make_message(8'h55, 32'h5555_5555, 29'h1555_5555, 1'b1, 4'd5,
                                  16'h5555, 64'h5555_5555_5555_5555, 1'b1));
        // Over-long and in-range length codes, copied into the len byte as is
        for (len = 1; len < 16; len += 2)
        begin
            send_message(make_message(8'($urandom_range(0, 255)), $urandom,
                                      29'($urandom_range(0, 32'h7FF)),
                                      1'b0, len[3:0], 16'($urandom_range(0, 65535)),
                                      {$urandom, $urandom}, 1'b1));
        end
        // Several link-down requests back to back, then a frame
        send_message(make_message(8'h12, 32'h1234_5678, 29'h123, 1'b0, 4'd2, 16'h10,
                                  64'h0, 1'b0));
        send_message(make_message(8'h13, 32'h1234_5679, 29'h124, 1'b0, 4'd2, 16'h10,
                                  64'h0, 1'b0));
        send_message(make_message(8'h14, 32'h1234_567A, 29'h125, 1'b0, 4'd2, 16'h10,
                                  64'h1, 1'b1));
        wait_drained();
    endtask

    // Hold the receiver off for a long stretch while requests keep coming
    // so the request queue fills and in_stall rises.
    task automatic test_backpressure();
        int i;
        tx_max_gap  = 0;
        rx_max_wait = 0;
        rx_hold_len = HOLD_CYCLES;
        for (i = 0; i < 8; i++)
        begin
            send_message(random_message(100));
        end
        wait_drained();
    endtask

    // Pause the sender until every byte of the previous frame has come
    task automatic test_sender_pause();
        int i;
        tx_max_gap  = 8;
        rx_max_wait = 8;
        for (i = 0; i < 4; i++)
        begin
            send_message(random_message(100));
            wait_drained();
        end
    endtask

    // Random traffic in phases with and without idling on each side; the
    // frame number wraps along the way.
    task automatic test_random();
        int i;
        int phase;
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            phase       = i / PHASE_ITEMS;
            tx_max_gap  = (phase % 3 == 1) ? 0 : 8;
            rx_max_wait = (phase % 4 == 2) ? 0 : 8;
            send_message(random_message((phase == 5) ? 40 : 85));
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial
    begin
        msg_count   = 16'd0;
        frame_num   = 8'd0;
        tx_max_gap  = 0;
        rx_max_wait = 0;
        rx_hold_len = 0;

        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        bus_number  <= '0;
        time_us     <= '0;
        can_id      <= '0;
        extended    <= 1'b0;
        data_length <= '0;
        timeout_ms  <= '0;
        payload     <= '0;
        link_up     <= 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_sender_pause();
        test_random();

        // Drop valid, drain, then let any stray bytes show up
        in_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
